// ===== src/rbsi_pkg.sv =====
// Shared types, constants and register codes of the ray/box slab intersection block.
package rbsi_pkg;

    localparam int COORD_W    = 32;
    localparam int EPS_W      = 16;
    localparam int NUM_AXES   = 3;
    localparam int NUM_LANES  = 2 * NUM_AXES;
    // Dividend magnitude is |plane - origin| << 16, padded to whole divider stages
    localparam int DIV_W      = 52;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 136;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_BOX_MIN_X = 3'd0;
    localparam cfg_idx_t CFG_BOX_MIN_Y = 3'd1;
    localparam cfg_idx_t CFG_BOX_MIN_Z = 3'd2;
    localparam cfg_idx_t CFG_BOX_MAX_X = 3'd3;
    localparam cfg_idx_t CFG_BOX_MAX_Y = 3'd4;
    localparam cfg_idx_t CFG_BOX_MAX_Z = 3'd5;
    localparam cfg_idx_t CFG_EPSILON   = 3'd6;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam logic signed [COORD_W-1:0] BOX_MIN_RESET = -32'sd65536;
    localparam logic signed [COORD_W-1:0] BOX_MAX_RESET = 32'sd65536;
    localparam logic [EPS_W-1:0]          EPS_RESET     = 16'd7;

endpackage

// ===== src/ray_box_slab_intersect.sv =====
// Top level of the pipelined ray versus axis-aligned box slab test.
// Throughput: one ray per cycle unless stalled; the six plane divisions run in a 13-stage
// radix-2 divider pipeline (4 quotient bits per stage), one lane per box plane.
// Backpressure freezes the whole pipeline; nothing is dropped or repeated.
// Reset: asynchronous, active low; clears valid bits and loads the unit box, epsilon 7.
module ray_box_slab_intersect (
    input  logic                               clk,
    input  logic                               rst_n,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [rbsi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // distance, point_x, point_y, point_z, normal_axis, normal_negative, zero pad
    output logic [rbsi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // hit
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbsi_pkg::COORD_W-1:0]       cfg_data
);
    import rbsi_pkg::*;

    // Configuration registers
    logic signed [COORD_W-1:0] bmin_reg [NUM_AXES];
    logic signed [COORD_W-1:0] bmax_reg [NUM_AXES];
    logic [EPS_W-1:0]          eps_reg;

    assign cfg_ready = 1'b1;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                bmin_reg[i] <= BOX_MIN_RESET;
                bmax_reg[i] <= BOX_MAX_RESET;
            end
            eps_reg <= EPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BOX_MIN_X: bmin_reg[0] <= cfg_data;
                CFG_BOX_MIN_Y: bmin_reg[1] <= cfg_data;
                CFG_BOX_MIN_Z: bmin_reg[2] <= cfg_data;
                CFG_BOX_MAX_X: bmax_reg[0] <= cfg_data;
                CFG_BOX_MAX_Y: bmax_reg[1] <= cfg_data;
                CFG_BOX_MAX_Z: bmax_reg[2] <= cfg_data;
                CFG_EPSILON:   eps_reg     <= cfg_data[EPS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Pipeline advances whenever the output slot is free or being drained
    logic en;
    logic out_vld_reg;
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- Stage 1: register the ray
    logic                      vld1_reg;
    logic signed [COORD_W-1:0] org1_reg [NUM_AXES];
    logic signed [COORD_W-1:0] dir1_reg [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (en)
            vld1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                org1_reg[i] <= s_axis_tdata[i*COORD_W +: COORD_W];
                dir1_reg[i] <= s_axis_tdata[(NUM_AXES+i)*COORD_W +: COORD_W];
            end
        end
    end

    // ---------------- Stage 2: clamp directions, form plane offsets
    logic                      vld2_reg;
    logic signed [COORD_W-1:0] org2_reg  [NUM_AXES];
    logic signed [COORD_W-1:0] cdir2_reg [NUM_AXES];
    logic signed [COORD_W:0]   da2_reg   [NUM_AXES];
    logic signed [COORD_W:0]   db2_reg   [NUM_AXES];
    logic signed [COORD_W-1:0] cdir2_next [NUM_AXES];
    logic [EPS_W-1:0]          eps_eff;

    assign eps_eff = (eps_reg == '0) ? EPS_W'(1) : eps_reg;

    always_comb
    begin
        logic signed [COORD_W:0] d33;
        logic [COORD_W:0]        mag;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            d33 = {dir1_reg[i][COORD_W-1], dir1_reg[i]};
            mag = d33[COORD_W] ? (COORD_W+1)'(-d33) : d33;
            cdir2_next[i] = (mag < (COORD_W+1)'(eps_eff)) ? COORD_W'(eps_eff) : dir1_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (en)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                org2_reg[i]  <= org1_reg[i];
                cdir2_reg[i] <= cdir2_next[i];
                da2_reg[i]   <= (COORD_W+1)'(bmax_reg[i]) - (COORD_W+1)'(org1_reg[i]);
                db2_reg[i]   <= (COORD_W+1)'(bmin_reg[i]) - (COORD_W+1)'(org1_reg[i]);
            end
        end
    end

    // ---------------- Divider pipeline: stage 0 loads magnitudes, stages 1..N iterate
    logic                      div_vld_reg  [0:DIV_STAGES];
    logic signed [COORD_W-1:0] div_org_reg  [0:DIV_STAGES][NUM_AXES];
    logic signed [COORD_W-1:0] div_cdir_reg [0:DIV_STAGES][NUM_AXES];
    logic [COORD_W-1:0]        div_dmag_reg [0:DIV_STAGES][NUM_AXES];
    logic [NUM_LANES-1:0]      div_qneg_reg [0:DIV_STAGES];
    logic [DIV_W-1:0]          div_n_reg    [0:DIV_STAGES][NUM_LANES];
    logic [DIV_W-1:0]          div_q_reg    [0:DIV_STAGES][NUM_LANES];
    logic [COORD_W-1:0]        div_r_reg    [0:DIV_STAGES][NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_vld_reg[0] <= 1'b0;
        else if (en)
            div_vld_reg[0] <= vld2_reg;
    end

    // Load sign-magnitude operands; lane 2i is the max plane, 2i+1 the min plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                div_org_reg[0][i]  <= org2_reg[i];
                div_cdir_reg[0][i] <= cdir2_reg[i];
                div_dmag_reg[0][i] <= cdir2_reg[i][COORD_W-1] ? COORD_W'(-cdir2_reg[i])
                                                              : cdir2_reg[i];
                div_qneg_reg[0][2*i]   <= da2_reg[i][COORD_W] ^ cdir2_reg[i][COORD_W-1];
                div_qneg_reg[0][2*i+1] <= db2_reg[i][COORD_W] ^ cdir2_reg[i][COORD_W-1];
                div_n_reg[0][2*i]   <= {3'b000, (da2_reg[i][COORD_W] ? (COORD_W+1)'(-da2_reg[i])
                                                                    : da2_reg[i]), 16'h0000};
                div_n_reg[0][2*i+1] <= {3'b000, (db2_reg[i][COORD_W] ? (COORD_W+1)'(-db2_reg[i])
                                                                    : db2_reg[i]), 16'h0000};
                div_q_reg[0][2*i]   <= '0;
                div_q_reg[0][2*i+1] <= '0;
                div_r_reg[0][2*i]   <= '0;
                div_r_reg[0][2*i+1] <= '0;
            end
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic [DIV_W-1:0]   n_next [NUM_LANES];
        logic [DIV_W-1:0]   q_next [NUM_LANES];
        logic [COORD_W-1:0] r_next [NUM_LANES];

        // Retire DIV_BITS quotient bits per lane by shift and conditional subtract
        always_comb
        begin
            logic [DIV_W-1:0]   n;
            logic [DIV_W-1:0]   q;
            logic [COORD_W:0]   r2;
            logic [COORD_W:0]   dv;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                n  = div_n_reg[s][l];
                q  = div_q_reg[s][l];
                r2 = {1'b0, div_r_reg[s][l]};
                dv = {1'b0, div_dmag_reg[s][l/2]};
                for (int b = 0; b < DIV_BITS; b++)
                begin
                    r2 = {r2[COORD_W-1:0], n[DIV_W-1]};
                    n  = {n[DIV_W-2:0], 1'b0};
                    if (r2 >= dv)
                    begin
                        r2 = r2 - dv;
                        q  = {q[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q  = {q[DIV_W-2:0], 1'b0};
                    end
                end
                n_next[l] = n;
                q_next[l] = q;
                r_next[l] = r2[COORD_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_vld_reg[s+1] <= 1'b0;
            else if (en)
                div_vld_reg[s+1] <= div_vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_qneg_reg[s+1] <= div_qneg_reg[s];
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    div_org_reg[s+1][i]  <= div_org_reg[s][i];
                    div_cdir_reg[s+1][i] <= div_cdir_reg[s][i];
                    div_dmag_reg[s+1][i] <= div_dmag_reg[s][i];
                end
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    div_n_reg[s+1][l] <= n_next[l];
                    div_q_reg[s+1][l] <= q_next[l];
                    div_r_reg[s+1][l] <= r_next[l];
                end
            end
        end
    end

    // ---------------- Post 1: apply sign and saturate plane parameters
    logic                      vld_p1_reg;
    logic signed [COORD_W-1:0] org_p1_reg  [NUM_AXES];
    logic signed [COORD_W-1:0] cdir_p1_reg [NUM_AXES];
    logic signed [COORD_W-1:0] t_p1_reg    [NUM_LANES];
    logic signed [COORD_W-1:0] t_p1_next   [NUM_LANES];

    always_comb
    begin
        logic [DIV_W-1:0] q;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            q = div_q_reg[DIV_STAGES][l];
            if (!div_qneg_reg[DIV_STAGES][l])
                t_p1_next[l] = (q > DIV_W'(Q_MAX)) ? Q_MAX : q[COORD_W-1:0];
            else
                t_p1_next[l] = (q > DIV_W'(33'h1_0000_0000 >> 1)) ? Q_MIN
                                                                    : -q[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p1_reg <= 1'b0;
        else if (en)
            vld_p1_reg <= div_vld_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                org_p1_reg[i]  <= div_org_reg[DIV_STAGES][i];
                cdir_p1_reg[i] <= div_cdir_reg[DIV_STAGES][i];
            end
            for (int l = 0; l < NUM_LANES; l++)
                t_p1_reg[l] <= t_p1_next[l];
        end
    end

    // ---------------- Post 2: order near and far per axis
    logic                      vld_p2_reg;
    logic signed [COORD_W-1:0] org_p2_reg  [NUM_AXES];
    logic signed [COORD_W-1:0] cdir_p2_reg [NUM_AXES];
    logic signed [COORD_W-1:0] near_p2_reg [NUM_AXES];
    logic signed [COORD_W-1:0] far_p2_reg  [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p2_reg <= 1'b0;
        else if (en)
            vld_p2_reg <= vld_p1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                org_p2_reg[i]  <= org_p1_reg[i];
                cdir_p2_reg[i] <= cdir_p1_reg[i];
                if (t_p1_reg[2*i] < t_p1_reg[2*i+1])
                begin
                    near_p2_reg[i] <= t_p1_reg[2*i];
                    far_p2_reg[i]  <= t_p1_reg[2*i+1];
                end
                else
                begin
                    near_p2_reg[i] <= t_p1_reg[2*i+1];
                    far_p2_reg[i]  <= t_p1_reg[2*i];
                end
            end
        end
    end

    // ---------------- Post 3: entry is the largest near, exit the smallest far
    logic                      vld_p3_reg;
    logic signed [COORD_W-1:0] org_p3_reg  [NUM_AXES];
    logic signed [COORD_W-1:0] cdir_p3_reg [NUM_AXES];
    logic signed [COORD_W-1:0] near_p3_reg [NUM_AXES];
    logic signed [COORD_W-1:0] enter_p3_reg;
    logic signed [COORD_W-1:0] exit_p3_reg;
    logic signed [COORD_W-1:0] enter_p3_next;
    logic signed [COORD_W-1:0] exit_p3_next;

    always_comb
    begin
        enter_p3_next = near_p2_reg[0];
        exit_p3_next  = far_p2_reg[0];
        for (int i = 1; i < NUM_AXES; i++)
        begin
            if (near_p2_reg[i] > enter_p3_next)
                enter_p3_next = near_p2_reg[i];
            if (far_p2_reg[i] < exit_p3_next)
                exit_p3_next = far_p2_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p3_reg <= 1'b0;
        else if (en)
            vld_p3_reg <= vld_p2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                org_p3_reg[i]  <= org_p2_reg[i];
                cdir_p3_reg[i] <= cdir_p2_reg[i];
                near_p3_reg[i] <= near_p2_reg[i];
            end
            enter_p3_reg <= enter_p3_next;
            exit_p3_reg  <= exit_p3_next;
        end
    end

    // ---------------- Post 4: hit decision, entered face, direction times entry
    logic                        vld_p4_reg;
    logic                        hit_p4_reg;
    logic signed [COORD_W-1:0]   enter_p4_reg;
    logic signed [COORD_W-1:0]   org_p4_reg  [NUM_AXES];
    logic signed [2*COORD_W-1:0] prod_p4_reg [NUM_AXES];
    axis_t                       axis_p4_reg;
    logic                        neg_p4_reg;
    axis_t                       axis_p4_next;

    always_comb
    begin
        if (near_p3_reg[0] == enter_p3_reg)
            axis_p4_next = AXIS_X;
        else if (near_p3_reg[1] == enter_p3_reg)
            axis_p4_next = AXIS_Y;
        else
            axis_p4_next = AXIS_Z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p4_reg <= 1'b0;
        else if (en)
            vld_p4_reg <= vld_p3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_p4_reg   <= !(enter_p3_reg > exit_p3_reg || exit_p3_reg < 0);
            enter_p4_reg <= enter_p3_reg;
            axis_p4_reg  <= axis_p4_next;
            neg_p4_reg   <= !cdir_p3_reg[axis_p4_next][COORD_W-1];
            for (int i = 0; i < NUM_AXES; i++)
            begin
                org_p4_reg[i]  <= org_p3_reg[i];
                prod_p4_reg[i] <= (2*COORD_W)'(cdir_p3_reg[i]) * (2*COORD_W)'(enter_p3_reg);
            end
        end
    end

    // ---------------- Post 5: scale products back to Q16.16, toward zero, saturated
    logic                      vld_p5_reg;
    logic                      hit_p5_reg;
    logic signed [COORD_W-1:0] enter_p5_reg;
    logic signed [COORD_W-1:0] org_p5_reg [NUM_AXES];
    logic signed [COORD_W-1:0] ofs_p5_reg [NUM_AXES];
    axis_t                     axis_p5_reg;
    logic                      neg_p5_reg;
    logic signed [COORD_W-1:0] ofs_p5_next [NUM_AXES];

    always_comb
    begin
        logic signed [2*COORD_W-17:0] sh;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sh = prod_p4_reg[i][2*COORD_W-1:16];
            if (prod_p4_reg[i][2*COORD_W-1] && (prod_p4_reg[i][15:0] != '0))
                sh = sh + (2*COORD_W-16)'(1);
            if (sh > (2*COORD_W-16)'(Q_MAX))
                ofs_p5_next[i] = Q_MAX;
            else if (sh < (2*COORD_W-16)'(Q_MIN))
                ofs_p5_next[i] = Q_MIN;
            else
                ofs_p5_next[i] = sh[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p5_reg <= 1'b0;
        else if (en)
            vld_p5_reg <= vld_p4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_p5_reg   <= hit_p4_reg;
            enter_p5_reg <= enter_p4_reg;
            axis_p5_reg  <= axis_p4_reg;
            neg_p5_reg   <= neg_p4_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                org_p5_reg[i] <= org_p4_reg[i];
                ofs_p5_reg[i] <= ofs_p5_next[i];
            end
        end
    end

    // ---------------- Output register: add origin, saturate, blank a miss
    logic                      hit_out_reg;
    logic signed [COORD_W-1:0] dist_out_reg;
    logic signed [COORD_W-1:0] pt_out_reg [NUM_AXES];
    axis_t                     axis_out_reg;
    logic                      neg_out_reg;
    logic signed [COORD_W-1:0] pt_out_next [NUM_AXES];

    always_comb
    begin
        logic signed [COORD_W:0] sum;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sum = (COORD_W+1)'(org_p5_reg[i]) + (COORD_W+1)'(ofs_p5_reg[i]);
            if (sum > (COORD_W+1)'(Q_MAX))
                pt_out_next[i] = Q_MAX;
            else if (sum < (COORD_W+1)'(Q_MIN))
                pt_out_next[i] = Q_MIN;
            else
                pt_out_next[i] = sum[COORD_W-1:0];
            if (!hit_p5_reg)
                pt_out_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_p5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_out_reg  <= hit_p5_reg;
            dist_out_reg <= hit_p5_reg ? enter_p5_reg : Q_MAX;
            axis_out_reg <= hit_p5_reg ? axis_p5_reg : AXIS_X;
            neg_out_reg  <= hit_p5_reg && neg_p5_reg;
            for (int i = 0; i < NUM_AXES; i++)
                pt_out_reg[i] <= pt_out_next[i];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = hit_out_reg;
    assign m_axis_tdata  = {5'b00000, neg_out_reg, axis_out_reg,
                            pt_out_reg[2], pt_out_reg[1], pt_out_reg[0], dist_out_reg};

`ifndef SYNTH
    // A miss carries the far distance and nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !hit_out_reg) |->
            (dist_out_reg == Q_MAX && axis_out_reg == AXIS_X && !neg_out_reg))
        else $error("miss result not blanked");

    // A hit names an existing axis
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && hit_out_reg) |->
            (axis_out_reg == AXIS_X || axis_out_reg == AXIS_Y || axis_out_reg == AXIS_Z))
        else $error("hit with bad normal axis");

    // Lane 0 divider remainder stays below the divisor after the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        div_vld_reg[1] |-> (div_r_reg[1][0] < div_dmag_reg[1][0]))
        else $error("divider remainder out of range");

    // An interval with entry no later than exit and a non-negative exit is registered as a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_p3_reg && !(enter_p3_reg > exit_p3_reg) && !(exit_p3_reg < 0)) |=>
            hit_p4_reg)
        else $error("hit decision lost");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking stream testbench for the ray versus axis-aligned box slab test.
module tb;
    import rbsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_RAYS  = 1600;
    localparam int NUM_BOXES    = 7;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 200;

    typedef logic signed [COORD_W-1:0] q_t;

    typedef struct {
        q_t org [NUM_AXES];
        q_t dir [NUM_AXES];
    } ray_t;

    typedef struct {
        logic  hit;
        q_t    distance;
        q_t    point [NUM_AXES];
        axis_t axis;
        logic  negative;
    } hit_t;

    typedef struct {
        ray_t ray;
        bit   typed;
        hit_t want;
    } row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index = CFG_BOX_MIN_X;
    logic [COORD_W-1:0]     cfg_data = '0;

    // Shadow copy of the box registers
    q_t                box_lo [NUM_AXES];
    q_t                box_hi [NUM_AXES];
    logic [EPS_W-1:0]  eps_q;

    hit_t pending_hits [$];
    row_t rows [$];
    int   mismatches = 0;
    int   cycles = 0;
    int   rx_stall_pct = 0;
    int   tx_idle_pct = 0;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_cnt = 0;

    ray_box_slab_intersect u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp32(longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    // Slab test: clamp small directions, intersect the three slabs, pick the entered face
    function automatic hit_t slab_predict(ray_t r);
        hit_t   res;
        longint eps, o, d, mag, a, b, enter, leave;
        longint ov [NUM_AXES];
        longint dv [NUM_AXES];
        longint tn [NUM_AXES];
        longint tf [NUM_AXES];
        eps = (eps_q == 0) ? 1 : longint'(eps_q);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            o = longint'(r.org[i]);
            d = longint'(r.dir[i]);
            mag = (d < 0) ? -d : d;
            dv[i] = (mag < eps) ? eps : d;
            ov[i] = o;
            a = clamp32((longint'(box_hi[i]) - o) * 65536 / dv[i]);
            b = clamp32((longint'(box_lo[i]) - o) * 65536 / dv[i]);
            tn[i] = (a < b) ? a : b;
            tf[i] = (a < b) ? b : a;
        end
        enter = tn[0];
        leave = tf[0];
        for (int i = 1; i < NUM_AXES; i++)
        begin
            if (tn[i] > enter)
                enter = tn[i];
            if (tf[i] < leave)
                leave = tf[i];
        end
        res.hit = 1'b0;
        res.distance = Q_MAX;
        res.axis = AXIS_X;
        res.negative = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
            res.point[i] = '0;
        if (enter > leave || leave < 0)
            return res;
        res.hit = 1'b1;
        res.distance = q_t'(enter);
        for (int i = 0; i < NUM_AXES; i++)
            res.point[i] = q_t'(clamp32(ov[i] + clamp32(dv[i] * enter / 65536)));
        if (enter == tn[0])
            res.axis = AXIS_X;
        else if (enter == tn[1])
            res.axis = AXIS_Y;
        else
            res.axis = AXIS_Z;
        res.negative = (dv[res.axis] > 0);
        return res;
    endfunction

    function automatic ray_t mk_ray(q_t ox, q_t oy, q_t oz, q_t dx, q_t dy, q_t dz);
        ray_t r;
        r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
        r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
        return r;
    endfunction

    function automatic void add_row(ray_t r);
        row_t w;
        w.ray = r;
        w.typed = 1'b0;
        rows.push_back(w);
    endfunction

    // Ray aimed at a random point of the box, or pure noise now and then
    function automatic ray_t random_ray();
        ray_t   r;
        longint span, lo, tgt, d, s;
        int     pick;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            r.org[i] = q_t'($urandom);
            r.dir[i] = q_t'($urandom);
        end
        if (pick < 15)
            return r;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            lo = (box_lo[i] < box_hi[i]) ? longint'(box_lo[i]) : longint'(box_hi[i]);
            span = longint'(box_hi[i]) - longint'(box_lo[i]);
            if (span < 0)
                span = -span;
            tgt = lo + longint'({$urandom, $urandom} % (longint'(span) + 1));
            if (pick < 30)
                d = longint'($urandom_range(0, 2 * eps_q + 2)) - eps_q - 1;
            else
                d = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
            s = $urandom_range(0, 1 << 18);
            r.dir[i] = q_t'(d);
            r.org[i] = q_t'(clamp32(tgt - d * s / 65536));
        end
        return r;
    endfunction

    // Hold each config transfer until accepted; the caller lowers valid afterwards
    task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < CFG_BOX_MAX_X)
            box_lo[idx] = q_t'(val);
        else if (idx < CFG_EPSILON)
            box_hi[idx - CFG_BOX_MAX_X] = q_t'(val);
        else
            eps_q = val[EPS_W-1:0];
    endtask

    task automatic load_box(q_t lx, q_t ly, q_t lz, q_t hx, q_t hy, q_t hz,
                            logic [EPS_W-1:0] e);
        wait (pending_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_BOX_MIN_X, lx);
        write_reg(CFG_BOX_MIN_Y, ly);
        write_reg(CFG_BOX_MIN_Z, lz);
        write_reg(CFG_BOX_MAX_X, hx);
        write_reg(CFG_BOX_MAX_Y, hy);
        write_reg(CFG_BOX_MAX_Z, hz);
        write_reg(CFG_EPSILON, {{(COORD_W-EPS_W){1'b0}}, e});
        cfg_valid <= 1'b0;
    endtask

    // Offer one ray, hold it until the transfer, then log what must come back
    task automatic send_ray(row_t w);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.ray.dir[2], w.ray.dir[1], w.ray.dir[0],
                          w.ray.org[2], w.ray.org[1], w.ray.org[0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_hits.push_back(w.typed ? w.want : slab_predict(w.ray));
    endtask

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_cnt <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Compare each output transfer with the oldest expected result
    always @(posedge clk)
    begin
        hit_t want;
        hit_t got;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.hit      = m_axis_tuser[0];
            got.distance = m_axis_tdata[31:0];
            got.point[0] = m_axis_tdata[63:32];
            got.point[1] = m_axis_tdata[95:64];
            got.point[2] = m_axis_tdata[127:96];
            got.axis     = m_axis_tdata[129:128];
            got.negative = m_axis_tdata[130];
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit %0b dist %0d", got.hit, got.distance);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit || got.distance !== want.distance ||
                    got.point[0] !== want.point[0] || got.point[1] !== want.point[1] ||
                    got.point[2] !== want.point[2] || got.axis !== want.axis ||
                    got.negative !== want.negative)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp hit %0b d %0d p %0d %0d %0d ax %0d n %0b",
                                 want.hit, want.distance, want.point[0], want.point[1],
                                 want.point[2], want.axis, want.negative);
                        $display("          got hit %0b d %0d p %0d %0d %0d ax %0d n %0b",
                                 got.hit, got.distance, got.point[0], got.point[1],
                                 got.point[2], got.axis, got.negative);
                    end
                end
            end
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t w;
        hit_t h;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            box_lo[i] = BOX_MIN_RESET;
            box_hi[i] = BOX_MAX_RESET;
        end
        eps_q = EPS_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight hit on the -z face of the reset unit box
        w.ray = mk_ray(0, 0, -131072, 0, 0, 65536);
        w.typed = 1'b1;
        w.want.hit = 1'b1;
        w.want.distance = 65536;
        w.want.point[0] = 7;
        w.want.point[1] = 7;
        w.want.point[2] = -65536;
        w.want.axis = AXIS_Z;
        w.want.negative = 1'b1;
        rows.push_back(w);
        // Ray pointing away: the whole box lies behind it
        w.ray = mk_ray(0, 0, -131072, 0, 0, -65536);
        h.hit = 1'b0;
        h.distance = Q_MAX;
        h.point[0] = 0; h.point[1] = 0; h.point[2] = 0;
        h.axis = AXIS_X;
        h.negative = 1'b0;
        w.want = h;
        rows.push_back(w);
        // Diagonal ray: all three near times tie, x wins
        add_row(mk_ray(-131072, -131072, -131072, 65536, 65536, 65536));
        // Origin inside the box gives a negative entry
        add_row(mk_ray(0, 0, 0, 65536, -32768, 16384));
        add_row(mk_ray(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        add_row(mk_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        add_row(mk_ray(Q_MAX, 0, Q_MIN, Q_MIN, 1, Q_MAX));
        add_row(mk_ray(0, 0, 0, 0, 0, 0));
        add_row(mk_ray(0, 0, 300000, -3, 6, -7));
        add_row(mk_ray(0, -200000, 0, 8, 65536, -8));
        add_row(mk_ray(-1, -1, -1, -1, -1, -1));
        add_row(mk_ray(131072, 131072, 0, -65536, -65536, 1));
        add_row(mk_ray(65536, 0, 0, 65536, 0, 0));
        add_row(mk_ray(-65536, -65536, -65536, 1, 1, 1));
        add_row(mk_ray(Q_MIN, 0, 0, 1, 0, 0));
        add_row(mk_ray(0, Q_MAX, 0, 0, -1, 0));
        foreach (rows[i])
            send_ray(rows[i]);
        s_axis_tvalid <= 1'b0;

        // Random part: several box settings, three idling modes across the run
        for (int b = 0; b < NUM_BOXES; b++)
        begin
            case (b)
                0: load_box(-65536, -65536, -65536, 65536, 65536, 65536, EPS_W'(1));
                1: load_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF);
                2: load_box(65536, 65536, 65536, -65536, -65536, -65536, EPS_W'(0));
                3: load_box(-3 << 16, 0, 100, 5 << 16, 2 << 16, 400000, EPS_W'(7));
                4: load_box(q_t'($urandom), q_t'($urandom), q_t'($urandom),
                            q_t'($urandom), q_t'($urandom), q_t'($urandom),
                            EPS_W'($urandom));
                5: load_box(Q_MAX, Q_MIN, 0, Q_MAX, Q_MIN, 0, 16'h8000);
                default: load_box(-(10 << 16), -(1 << 16), -(4 << 16),
                                  10 << 16, 1 << 16, 4 << 16, EPS_W'(300));
            endcase
            for (int k = 0; k < RANDOM_RAYS / NUM_BOXES; k++)
            begin
                int pos;
                pos = b * (RANDOM_RAYS / NUM_BOXES) + k;
                if (pos < RANDOM_RAYS / 3)
                begin
                    tx_idle_pct = 25;
                    rx_stall_pct = 66;
                end
                else if (pos < 2 * RANDOM_RAYS / 3)
                begin
                    tx_idle_pct = 66;
                    rx_stall_pct = 25;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                // Long receiver hold-off while rays keep coming
                if (pos == RANDOM_RAYS / 2 || pos == RANDOM_RAYS - 100)
                    hold_reqs++;
                w.ray = random_ray();
                w.typed = 1'b0;
                send_ray(w);
            end
            s_axis_tvalid <= 1'b0;
        end

        wait (pending_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rbsi_pkg.sv
src/ray_box_slab_intersect.sv
tb/tb.sv
